// ===== rtl/core/tccs_pkg.sv =====
package tccs_pkg;

   // Field widths of the request and response transactions.
   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int POS_W    = 11;
   localparam int CELL_W   = 16;
   localparam int ATTR_W   = 8;

   // Configuration port widths.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_PUT  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SET  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

   // Register index of the attribute register.
   localparam logic [0:0] REG_TEXT_ATTRIBUTE = 1'b0;

   // Character and reset constants.
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic exec_put;
      logic exec_read;
      logic div_start;
      logic scroll_begin;
      logic scroll_done;
      logic set_load;
      logic sweep_run;
      logic sweep_clear;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_put;
      logic op_set;
      logic need_scroll;
      logic sweep_last;
      logic div_done;
   } status_type;

endpackage

// ===== rtl/core/text_console_cursor_scroll_core.sv =====
// Channel    Ports                                   Transfer
// request    start, busy, req_*                      start high while busy low
// response   rsp_strobe, rsp_*                       one cycle, no back pressure
// config     psel, penable, pwrite, paddr, pwdata,   APB write, pready tied high
//            prdata, pready
//
// A character or read goes from acceptance through EXEC to RESPOND, and busy is
// low again in the response cycle, so the next transaction can be accepted there.
// A put that scrolls first runs the row copy, which moves one cell per cycle
// through the single write port of the cell memory.
// A cursor load waits in SETPOS for the row divider, which needs two stages to
// split the position into row start and column.
// After reset the cell memory is cleared one cell per cycle with busy high;
// configuration writes are taken throughout.
module text_console_cursor_scroll_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tccs_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [tccs_pkg::CHAR_W-1:0]         req_char_code,
   input  logic [tccs_pkg::POS_W-1:0]          req_cell_position,
   output logic                                rsp_strobe,
   output logic [tccs_pkg::CELL_W-1:0]         rsp_read_data,
   output logic [tccs_pkg::POS_W-1:0]          rsp_cursor_after,
   output logic                                rsp_did_scroll,
   output logic                                rsp_did_write,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tccs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tccs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tccs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   tccs_pkg::ctrl_type   ctrl;
   tccs_pkg::status_type stat;

   logic [tccs_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic                        reg_sel;

   // Register decode: one register at byte address zero.
   assign reg_sel = (paddr[2:2] == tccs_pkg::REG_TEXT_ATTRIBUTE);
   assign pready  = 1'b1;

   always_comb begin
      attr_in = attr_ff;
      if (psel && penable && pwrite && pready && reg_sel) begin
         attr_in = pwdata[tccs_pkg::ATTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tccs_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   assign prdata = reg_sel ? tccs_pkg::CSR_DATA_W'(attr_ff) : '0;

   tccs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   tccs_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .attr              (attr_ff),
      .req_opcode        (req_opcode),
      .req_char_code     (req_char_code),
      .req_cell_position (req_cell_position),
      .rsp_read_data     (rsp_read_data),
      .rsp_cursor_after  (rsp_cursor_after),
      .rsp_did_scroll    (rsp_did_scroll),
      .rsp_did_write     (rsp_did_write)
   );

   // An accepted transaction keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after a request was accepted");

   // No response appears in the cycle after an acceptance.
   a_accept_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("response strobe right after a request was accepted");

   // The response cycle also accepts the next transaction.
   a_rsp_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy high during a response");

   // Read data only comes with a read, which never writes or scrolls.
   a_read_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_read_data != '0)) |-> (!rsp_did_write && !rsp_did_scroll))
      else $error("read data on a response that wrote or scrolled");

endmodule

// ===== rtl/core/tccs_ram.sv =====
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tccs_rowdiv.sv =====
module tccs_rowdiv #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [$clog2(COLUMNS*ROWS+1)-1:0]      value,
   output logic                                   done,
   output logic [$clog2(COLUMNS*ROWS+1)-1:0]      base,
   output logic [$clog2(COLUMNS)-1:0]             col
);

   localparam int CELLS   = COLUMNS * ROWS;
   localparam int VAL_W   = $clog2(CELLS + 1);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int SHIFT   = VAL_W + COL_W;
   localparam int RECIP_W = VAL_W + 2;
   localparam int PROD_W  = VAL_W + RECIP_W;
   // Scaled reciprocal of COLUMNS, rounded up so that the quotient is exact
   // for every value below 2**VAL_W.
   localparam longint RECIP = (longint'(1) << SHIFT) / COLUMNS + 1;

   logic [PROD_W-1:0] product;
   logic [VAL_W-1:0]  quot;
   logic [VAL_W-1:0]  row_start;

   logic [COL_W-1:0] val_ff, val_in;
   logic [VAL_W-1:0] quot_ff, quot_in;
   logic [VAL_W-1:0] base_ff, base_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             stage_ff, stage_in;
   logic             done_ff, done_in;

   // First stage: the row number from a multiply by the reciprocal.
   assign product = PROD_W'(value) * PROD_W'(RECIP);
   assign quot    = VAL_W'(product >> SHIFT);

   // Second stage: row start, and the column as what is left over.
   assign row_start = VAL_W'(quot_ff * VAL_W'(COLUMNS));

   always_comb begin
      val_in   = val_ff;
      quot_in  = quot_ff;
      base_in  = base_ff;
      col_in   = col_ff;
      stage_in = start;
      done_in  = stage_ff;
      if (start) begin
         val_in  = value[COL_W-1:0];
         quot_in = quot;
      end
      if (stage_ff) begin
         base_in = row_start;
         col_in  = val_ff - row_start[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      val_ff  <= val_in;
      quot_ff <= quot_in;
      base_ff <= base_in;
      col_ff  <= col_in;
   end

   assign done = done_ff;
   assign base = base_ff;
   assign col  = col_ff;

endmodule

// ===== rtl/core/tccs_datapath.sv =====
module tccs_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tccs_pkg::ctrl_type                  ctrl,
   output tccs_pkg::status_type                stat,
   input  logic [tccs_pkg::ATTR_W-1:0]         attr,
   input  logic [tccs_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [tccs_pkg::CHAR_W-1:0]         req_char_code,
   input  logic [tccs_pkg::POS_W-1:0]          req_cell_position,
   output logic [tccs_pkg::CELL_W-1:0]         rsp_read_data,
   output logic [tccs_pkg::POS_W-1:0]          rsp_cursor_after,
   output logic                                rsp_did_scroll,
   output logic                                rsp_did_write
);

   localparam int CELLS    = COLUMNS * ROWS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CURSOR_W = $clog2(CELLS + 1);
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int SRC_W    = CURSOR_W + 1;
   localparam int EXT_W    = CURSOR_W + tccs_pkg::POS_W;

   // Latched request.
   logic [tccs_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [tccs_pkg::CHAR_W-1:0]   ch_ff, ch_in;
   logic [tccs_pkg::POS_W-1:0]    pos_ff, pos_in;

   // Cursor kept as row start plus column.
   logic [CURSOR_W-1:0] row_base_ff, row_base_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [CURSOR_W-1:0] cursor;

   // Sweep index and the pending write of the copy pipeline.
   logic [ADDR_W-1:0] sweep_idx_ff, sweep_idx_in;
   logic              pend_valid_ff;
   logic [ADDR_W-1:0] pend_idx_ff;
   logic              pend_zero_ff;

   // Response flags.
   logic rd_hit_ff, rd_hit_in;
   logic wrote_ff, wrote_in;
   logic scrolled_ff, scrolled_in;

   // Memory ports.
   logic                        ram_wr_en;
   logic [ADDR_W-1:0]           ram_wr_addr;
   logic [tccs_pkg::CELL_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]           ram_rd_addr;
   logic [tccs_pkg::CELL_W-1:0] ram_rd_data;

   // Divider interface.
   logic [CURSOR_W-1:0] div_value;
   logic                div_done;
   logic [CURSOR_W-1:0] div_base;
   logic [COL_W-1:0]    div_col;

   logic [SRC_W-1:0]    sweep_src;
   logic                src_in_range;
   logic [EXT_W-1:0]    pos_ext;
   logic [EXT_W-1:0]    cells_ext;
   logic [EXT_W-1:0]    cursor_ext;
   logic                is_newline;

   assign cursor     = row_base_ff + CURSOR_W'(col_ff);
   assign is_newline = (ch_ff == tccs_pkg::NEWLINE_CODE);

   // Position compare and saturation in a width that holds both sides.
   assign pos_ext    = {{CURSOR_W{1'b0}}, pos_ff};
   assign cells_ext  = EXT_W'(CELLS);
   assign div_value  = (pos_ext > cells_ext) ? CURSOR_W'(CELLS) : pos_ext[CURSOR_W-1:0];
   assign cursor_ext = {{tccs_pkg::POS_W{1'b0}}, cursor};

   // Source of the scroll copy lies one row ahead of the destination.
   assign sweep_src    = SRC_W'(sweep_idx_ff) + SRC_W'(COLUMNS);
   assign src_in_range = (sweep_src < SRC_W'(CELLS));

   // Request latch and response flags.
   always_comb begin
      op_in       = op_ff;
      ch_in       = ch_ff;
      pos_in      = pos_ff;
      rd_hit_in   = rd_hit_ff;
      wrote_in    = wrote_ff;
      scrolled_in = scrolled_ff;
      if (ctrl.accept) begin
         op_in       = req_opcode;
         ch_in       = req_char_code;
         pos_in      = req_cell_position;
         rd_hit_in   = 1'b0;
         wrote_in    = 1'b0;
         scrolled_in = 1'b0;
      end
      if (ctrl.exec_read) begin
         rd_hit_in = (op_ff == tccs_pkg::OP_READ) && (pos_ext < cells_ext);
      end
      if (ctrl.exec_put && !is_newline) begin
         wrote_in = 1'b1;
      end
      if (ctrl.scroll_begin) begin
         scrolled_in = 1'b1;
      end
   end

   // Cursor update.
   always_comb begin
      row_base_in = row_base_ff;
      col_in      = col_ff;
      if (ctrl.scroll_done) begin
         row_base_in = CURSOR_W'(CELLS - COLUMNS);
         col_in      = '0;
      end else if (ctrl.set_load) begin
         row_base_in = div_base;
         col_in      = div_col;
      end else if (ctrl.exec_put) begin
         if (is_newline || (col_ff == COL_W'(COLUMNS - 1))) begin
            row_base_in = row_base_ff + CURSOR_W'(COLUMNS);
            col_in      = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Sweep index walks every cell once, then wraps to zero.
   always_comb begin
      sweep_idx_in = sweep_idx_ff;
      if (ctrl.sweep_run) begin
         sweep_idx_in = stat.sweep_last ? '0 : sweep_idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_base_ff   <= '0;
         col_ff        <= '0;
         sweep_idx_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rd_hit_ff     <= 1'b0;
         wrote_ff      <= 1'b0;
         scrolled_ff   <= 1'b0;
      end else begin
         row_base_ff   <= row_base_in;
         col_ff        <= col_in;
         sweep_idx_ff  <= sweep_idx_in;
         pend_valid_ff <= ctrl.sweep_run;
         rd_hit_ff     <= rd_hit_in;
         wrote_ff      <= wrote_in;
         scrolled_ff   <= scrolled_in;
      end
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      pos_ff       <= pos_in;
      pend_idx_ff  <= sweep_idx_ff;
      pend_zero_ff <= ctrl.sweep_clear || !src_in_range;
   end

   // Read port: the sweep source while sweeping, else the read position.
   always_comb begin
      ram_rd_addr = pos_ext[ADDR_W-1:0];
      if (ctrl.sweep_run && src_in_range) begin
         ram_rd_addr = sweep_src[ADDR_W-1:0];
      end
   end

   // Write port: the pending sweep write, else a character write.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor[ADDR_W-1:0];
      ram_wr_data = {attr, ch_ff};
      if (pend_valid_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pend_idx_ff;
         ram_wr_data = pend_zero_ff ? '0 : ram_rd_data;
      end else if (ctrl.exec_put && !is_newline) begin
         ram_wr_en = 1'b1;
      end
   end

   tccs_ram #(
      .WIDTH (tccs_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tccs_rowdiv #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_rowdiv (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .value (div_value),
      .done  (div_done),
      .base  (div_base),
      .col   (div_col)
   );

   // Status to the controller.
   assign stat.op_put      = (op_ff == tccs_pkg::OP_PUT);
   assign stat.op_set      = (op_ff == tccs_pkg::OP_SET);
   assign stat.need_scroll = (cursor >= CURSOR_W'(CELLS));
   assign stat.sweep_last  = (sweep_idx_ff == ADDR_W'(CELLS - 1));
   assign stat.div_done    = div_done;

   // Response fields.
   assign rsp_read_data    = rd_hit_ff ? ram_rd_data : '0;
   assign rsp_cursor_after = cursor_ext[tccs_pkg::POS_W-1:0];
   assign rsp_did_scroll   = scrolled_ff;
   assign rsp_did_write    = wrote_ff;

endmodule

// ===== rtl/core/tccs_ctrl.sv =====
module tccs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   input  tccs_pkg::status_type stat,
   output tccs_pkg::ctrl_type   ctrl
);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_DRAINC  = 3'd1;
   localparam logic [2:0] ST_IDLE    = 3'd2;
   localparam logic [2:0] ST_EXEC    = 3'd3;
   localparam logic [2:0] ST_SCROLL  = 3'd4;
   localparam logic [2:0] ST_DRAINS  = 3'd5;
   localparam logic [2:0] ST_SETPOS  = 3'd6;
   localparam logic [2:0] ST_RESPOND = 3'd7;

   logic [2:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      ctrl       = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.sweep_run   = 1'b1;
            ctrl.sweep_clear = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_DRAINC;
            end
         end
         ST_DRAINC: begin
            state_in = ST_IDLE;
         end
         ST_IDLE, ST_RESPOND: begin
            busy       = 1'b0;
            rsp_strobe = (state_ff == ST_RESPOND);
            if (start) begin
               ctrl.accept = 1'b1;
               state_in    = ST_EXEC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EXEC: begin
            priority if (stat.op_put && stat.need_scroll) begin
               ctrl.scroll_begin = 1'b1;
               state_in          = ST_SCROLL;
            end else if (stat.op_put) begin
               ctrl.exec_put = 1'b1;
               state_in      = ST_RESPOND;
            end else if (stat.op_set) begin
               ctrl.div_start = 1'b1;
               state_in       = ST_SETPOS;
            end else begin
               ctrl.exec_read = 1'b1;
               state_in       = ST_RESPOND;
            end
         end
         ST_SCROLL: begin
            ctrl.sweep_run = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_DRAINS;
            end
         end
         ST_DRAINS: begin
            ctrl.scroll_done = 1'b1;
            state_in         = ST_EXEC;
         end
         ST_SETPOS: begin
            if (stat.div_done) begin
               ctrl.set_load = 1'b1;
               state_in      = ST_RESPOND;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // Screen geometry of the instance under test.
   localparam int COLUMNS        = 80;
   localparam int ROWS           = 25;
   localparam int SCREEN_SIZE    = COLUMNS * ROWS;
   localparam int LAST_ROW_START = SCREEN_SIZE - COLUMNS;
   localparam int POSITION_MAX   = (1 << tccs_pkg::POS_W) - 1;

   // The fourth opcode is not assigned and must leave the state alone.
   localparam logic [tccs_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [tccs_pkg::CSR_ADDR_W-1:0] ATTR_ADDR =
      tccs_pkg::CSR_ADDR_W'(4 * tccs_pkg::REG_TEXT_ATTRIBUTE);

   localparam int RANDOM_ITEMS = 450;
   localparam int MAX_GAP      = 6;
   localparam int PHASES       = 4;

   typedef struct packed {
      logic [tccs_pkg::CELL_W-1:0] read_data;
      logic [tccs_pkg::POS_W-1:0]  cursor_after;
      logic                        did_scroll;
      logic                        did_write;
   } console_result_type;

   typedef struct packed {
      logic [tccs_pkg::OPCODE_W-1:0] opcode;
      logic [tccs_pkg::CHAR_W-1:0]   char_code;
      logic [tccs_pkg::POS_W-1:0]    cell_position;
      logic                          typed;
      console_result_type            want;
   } directed_row_type;

   logic                            clock;
   logic                            reset             = 1'b1;
   logic                            start             = 1'b0;
   logic                            busy;
   logic [tccs_pkg::OPCODE_W-1:0]   req_opcode        = '0;
   logic [tccs_pkg::CHAR_W-1:0]     req_char_code     = '0;
   logic [tccs_pkg::POS_W-1:0]      req_cell_position = '0;
   logic                            rsp_strobe;
   logic [tccs_pkg::CELL_W-1:0]     rsp_read_data;
   logic [tccs_pkg::POS_W-1:0]      rsp_cursor_after;
   logic                            rsp_did_scroll;
   logic                            rsp_did_write;
   logic                            psel              = 1'b0;
   logic                            penable           = 1'b0;
   logic                            pwrite            = 1'b0;
   logic [tccs_pkg::CSR_ADDR_W-1:0] paddr             = '0;
   logic [tccs_pkg::CSR_DATA_W-1:0] pwdata            = '0;
   logic [tccs_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   // Shadow copy of the screen, cursor and attribute register.
   logic [tccs_pkg::CELL_W-1:0] screen_model [SCREEN_SIZE];
   int unsigned                 cursor_model;
   logic [tccs_pkg::ATTR_W-1:0] attribute_model;

   console_result_type pending_results [$];
   int                 error_count = 0;

   // Directed transactions. Rows marked typed carry a hand-computed response;
   // the others are checked against the screen model.
   directed_row_type directed_rows [25] = '{
      // Fresh screen: cell zero and an index past the end both read as zero.
      '{tccs_pkg::OP_READ, 8'h00, 11'd0, 1'b1,
        '{16'h0000, 11'd0, 1'b0, 1'b0}},
      '{tccs_pkg::OP_READ, 8'h00, 11'd2047, 1'b1,
        '{16'h0000, 11'd0, 1'b0, 1'b0}},
      // Character extremes with the reset attribute.
      '{tccs_pkg::OP_PUT, 8'h00, 11'd0, 1'b1,
        '{16'h0000, 11'd1, 1'b0, 1'b1}},
      '{tccs_pkg::OP_PUT, 8'hFF, 11'd0, 1'b1,
        '{16'h0000, 11'd2, 1'b0, 1'b1}},
      '{tccs_pkg::OP_READ, 8'h00, 11'd1, 1'b1,
        '{16'h07FF, 11'd2, 1'b0, 1'b0}},
      '{OP_UNUSED, 8'hFF, 11'd2047, 1'b1,
        '{16'h0000, 11'd2, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 11'd0, 1'b1,
        '{16'h0000, 11'd80, 1'b0, 1'b0}},
      // Fill the last cell, then the next character scrolls.
      '{tccs_pkg::OP_SET, 8'h00, 11'd1999, 1'b1,
        '{16'h0000, 11'd1999, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, 8'h5A, 11'd0, 1'b1,
        '{16'h0000, 11'd2000, 1'b0, 1'b1}},
      '{tccs_pkg::OP_READ, 8'h00, 11'd1999, 1'b1,
        '{16'h075A, 11'd2000, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, 8'h61, 11'd0, 1'b1,
        '{16'h0000, 11'd1921, 1'b1, 1'b1}},
      '{tccs_pkg::OP_READ, 8'h00, 11'd1919, 1'b1,
        '{16'h075A, 11'd1921, 1'b0, 1'b0}},
      '{tccs_pkg::OP_READ, 8'h00, 11'd1920, 1'b1,
        '{16'h0761, 11'd1921, 1'b0, 1'b0}},
      // A cursor load past the end saturates; a newline there scrolls first.
      '{tccs_pkg::OP_SET, 8'h00, 11'd2047, 1'b1,
        '{16'h0000, 11'd2000, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 11'd0, 1'b1,
        '{16'h0000, 11'd2000, 1'b1, 1'b0}},
      '{tccs_pkg::OP_READ, 8'h00, 11'd1920, 1'b1,
        '{16'h0000, 11'd2000, 1'b0, 1'b0}},
      // A newline on the last row only parks the cursor past the end.
      '{tccs_pkg::OP_SET, 8'h00, 11'd1920, 1'b1,
        '{16'h0000, 11'd1920, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 11'd0, 1'b1,
        '{16'h0000, 11'd2000, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, 8'h62, 11'd0, 1'b1,
        '{16'h0000, 11'd1921, 1'b1, 1'b1}},
      '{tccs_pkg::OP_SET, 8'h00, 11'd2000, 1'b1,
        '{16'h0000, 11'd2000, 1'b0, 1'b0}},
      '{tccs_pkg::OP_SET, 8'h00, 11'd1024, 1'b1,
        '{16'h0000, 11'd1024, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, 8'hAA, 11'd0, 1'b0,
        '{16'h0000, 11'd0, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 11'h555, 1'b0,
        '{16'h0000, 11'd0, 1'b0, 1'b0}},
      '{tccs_pkg::OP_READ, 8'h55, 11'd1024, 1'b0,
        '{16'h0000, 11'd0, 1'b0, 1'b0}},
      '{tccs_pkg::OP_PUT, 8'h55, 11'h2AA, 1'b0,
        '{16'h0000, 11'd0, 1'b0, 1'b0}}
   };

   text_console_cursor_scroll_core #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_char_code     (req_char_code),
      .req_cell_position (req_cell_position),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_data     (rsp_read_data),
      .rsp_cursor_after  (rsp_cursor_after),
      .rsp_did_scroll    (rsp_did_scroll),
      .rsp_did_write     (rsp_did_write),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Runs far past the slowest correct run, where every transaction scrolls.
   initial begin
      #50_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned wanted);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, wanted);
      error_count++;
   endtask

   // Applies one command to the screen model and returns the response it gives.
   function automatic console_result_type apply_command(
         input logic [tccs_pkg::OPCODE_W-1:0] opcode,
         input logic [tccs_pkg::CHAR_W-1:0]   char_code,
         input logic [tccs_pkg::POS_W-1:0]    position);
      console_result_type res;
      res = '0;
      case (opcode)
         tccs_pkg::OP_PUT: begin
            // A cursor at or past the end moves the screen up one row first.
            if (cursor_model >= SCREEN_SIZE) begin
               for (int i = 0; i < LAST_ROW_START; i++) screen_model[i] = screen_model[i + COLUMNS];
               for (int i = LAST_ROW_START; i < SCREEN_SIZE; i++) screen_model[i] = '0;
               cursor_model   = LAST_ROW_START;
               res.did_scroll = 1'b1;
            end
            if (char_code == tccs_pkg::NEWLINE_CODE) begin
               cursor_model += COLUMNS - (cursor_model % COLUMNS);
            end else begin
               screen_model[cursor_model] = {attribute_model, char_code};
               cursor_model++;
               res.did_write = 1'b1;
            end
         end
         tccs_pkg::OP_SET: begin
            cursor_model = (int'(position) > SCREEN_SIZE) ? SCREEN_SIZE : int'(position);
         end
         tccs_pkg::OP_READ: begin
            if (int'(position) < SCREEN_SIZE) res.read_data = screen_model[position];
         end
         default: begin
         end
      endcase
      res.cursor_after = tccs_pkg::POS_W'(cursor_model);
      return res;
   endfunction

   // Presents one request transaction and waits until the block takes it.
   // Start is left high so that a back-to-back transaction needs no toggle.
   task automatic issue_command(input logic [tccs_pkg::OPCODE_W-1:0] opcode,
                                input logic [tccs_pkg::CHAR_W-1:0] char_code,
                                input logic [tccs_pkg::POS_W-1:0] position,
                                input int gap, input logic typed,
                                input console_result_type want);
      console_result_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_opcode        <= opcode;
      req_char_code     <= char_code;
      req_cell_position <= position;
      do @(posedge clock); while (busy);
      predicted = apply_command(opcode, char_code, position);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // Writes the attribute register once the block has drained, then reads it back.
   task automatic write_attribute(input logic [tccs_pkg::ATTR_W-1:0] value);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ATTR_ADDR;
      pwdata  <= tccs_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (pready) attribute_model = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[tccs_pkg::ATTR_W-1:0] !== attribute_model)
         report_mismatch("attribute read back", prdata, attribute_model);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // One random sequence of transactions; returns how many it issued.
   task automatic random_burst(output int issued);
      int                          kind;
      int                          length;
      int                          gap_limit;
      int                          position;
      logic [tccs_pkg::CHAR_W-1:0] char_code;
      issued    = 0;
      gap_limit = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      kind      = $urandom_range(0, 9);
      if (kind < 6) begin
         // Writing run: place the cursor, mostly near the end so that runs scroll.
         if ($urandom_range(0, 2) != 0) position = $urandom_range(LAST_ROW_START - COLUMNS,
                                                                  POSITION_MAX);
         else position = $urandom_range(0, POSITION_MAX);
         issue_command(tccs_pkg::OP_SET, tccs_pkg::CHAR_W'($urandom),
                       tccs_pkg::POS_W'(position), $urandom_range(0, gap_limit),
                       1'b0, '0);
         length = $urandom_range(1, 14);
         repeat (length) begin
            char_code = ($urandom_range(0, 5) == 0) ? tccs_pkg::NEWLINE_CODE
                                                    : tccs_pkg::CHAR_W'($urandom);
            issue_command(tccs_pkg::OP_PUT, char_code, tccs_pkg::POS_W'($urandom),
                          $urandom_range(0, gap_limit), 1'b0, '0);
         end
         issued = length + 1;
         // Read back some of the cells just written.
         repeat ($urandom_range(0, 3)) begin
            position = int'(cursor_model) - int'($urandom_range(1, 20));
            if (position < 0) position = 0;
            issue_command(tccs_pkg::OP_READ, tccs_pkg::CHAR_W'($urandom),
                          tccs_pkg::POS_W'(position), $urandom_range(0, gap_limit),
                          1'b0, '0);
            issued++;
         end
      end else if (kind < 8) begin
         // Scattered reads anywhere, past the end of the screen included.
         length = $urandom_range(1, 6);
         repeat (length) issue_command(tccs_pkg::OP_READ, tccs_pkg::CHAR_W'($urandom),
                                       tccs_pkg::POS_W'($urandom),
                                       $urandom_range(0, gap_limit), 1'b0, '0);
         issued = length;
      end else begin
         // Noise: any opcode and any field values.
         length = $urandom_range(1, 6);
         repeat (length) issue_command(tccs_pkg::OPCODE_W'($urandom),
                                       tccs_pkg::CHAR_W'($urandom),
                                       tccs_pkg::POS_W'($urandom),
                                       $urandom_range(0, gap_limit), 1'b0, '0);
         issued = length;
      end
   endtask

   // Compare each response transaction with the oldest outstanding prediction.
   always @(posedge clock) begin
      console_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_cursor_after, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_cursor_after !== want.cursor_after)
               report_mismatch("cursor_after", rsp_cursor_after, want.cursor_after);
            if (rsp_did_scroll !== want.did_scroll)
               report_mismatch("did_scroll", rsp_did_scroll, want.did_scroll);
            if (rsp_did_write !== want.did_write)
               report_mismatch("did_write", rsp_did_write, want.did_write);
         end
      end
   end

   // Main sequence: reset, directed rows, then random phases at several attributes.
   initial begin
      int                          issued;
      int                          random_done;
      logic [tccs_pkg::ATTR_W-1:0] phase_attribute;
      for (int i = 0; i < SCREEN_SIZE; i++) screen_model[i] = '0;
      cursor_model    = 0;
      attribute_model = tccs_pkg::ATTR_RESET;
      random_done     = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue_command(directed_rows[i].opcode, directed_rows[i].char_code,
                       directed_rows[i].cell_position, $urandom_range(0, MAX_GAP),
                       directed_rows[i].typed, directed_rows[i].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) phase_attribute = '0;
         else if (phase == 1) phase_attribute = '1;
         else phase_attribute = tccs_pkg::ATTR_W'($urandom);
         write_attribute(phase_attribute);
         while (random_done < (phase + 1) * RANDOM_ITEMS / PHASES) begin
            random_burst(issued);
            random_done += issued;
         end
      end

      // Drain, then allow for the response latency before closing.
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tccs_pkg.sv
rtl/core/tccs_ram.sv
rtl/core/tccs_rowdiv.sv
rtl/core/tccs_datapath.sv
rtl/core/tccs_ctrl.sv
rtl/core/text_console_cursor_scroll_core.sv
dv/testbench.sv
